// ===== design/fca_pkg.sv =====
`default_nettype none

package fca_pkg;

    // input field widths
    localparam int ET_W   = 16;
    localparam int TS_W   = 16;
    localparam int PROD_W = ET_W + TS_W;

    // frames per second is 30 = 32 - 2, so the scaled product grows by 5 bits
    localparam int SCALED_W = PROD_W + 5;
    localparam int FRAC_W   = 16;
    localparam int REM_W    = SCALED_W - FRAC_W;

    // one frame in Q.8
    localparam int ONE_FRAME = 256;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_FRAME = 2'd0,
        REG_END_FRAME   = 2'd1,
        REG_LOOP_ENABLE = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== design/fca_queue.sv =====
`default_nettype none

module fca_queue #(
    parameter int WIDTH = 46
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full  = (count_reg == 2'(DEPTH));
    assign empty = (count_reg == 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== design/fca_front.sv =====
`default_nettype none

module fca_front #(
    parameter int FRAME_WIDTH = 24
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [FRAME_WIDTH-1:0]          current_frame,
    input  wire logic        [fca_pkg::ET_W-1:0]        elapsed_time,
    input  wire logic        [fca_pkg::TS_W-1:0]        time_scale,
    input  wire logic signed [FRAME_WIDTH-1:0]          start_frame,
    input  wire logic signed [FRAME_WIDTH-1:0]          end_frame,
    input  wire logic                                   q_full,
    output logic                                        q_push,
    output logic [1+fca_pkg::REM_W+FRAME_WIDTH-1:0]     q_wdata
);

    logic                                  s1_valid_reg;
    logic                                  s1_valid_next;
    logic signed [FRAME_WIDTH-1:0]         s1_frame_reg;
    logic        [fca_pkg::PROD_W-1:0]     s1_prod_reg;
    logic                                  accept;
    logic        [fca_pkg::SCALED_W-1:0]   prod_ext;
    logic        [fca_pkg::SCALED_W-1:0]   scaled;
    logic        [fca_pkg::REM_W-1:0]      remain;
    logic signed [FRAME_WIDTH-1:0]         lo;
    logic signed [FRAME_WIDTH:0]           span;
    logic                                  single;

    assign in_stall = s1_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = s1_valid_reg && !q_full;

    always_comb
    begin
        // times 30 as times 32 minus times 2
        prod_ext = fca_pkg::SCALED_W'(s1_prod_reg);
        scaled   = (prod_ext << 5) - (prod_ext << 1);
        remain   = scaled[fca_pkg::SCALED_W-1:fca_pkg::FRAC_W];
        lo       = (start_frame < end_frame) ? start_frame : end_frame;
        span     = (FRAME_WIDTH+1)'(end_frame) - (FRAME_WIDTH+1)'(lo);
        single   = (span <= (FRAME_WIDTH+1)'(fca_pkg::ONE_FRAME));
        q_wdata  = {single, remain, s1_frame_reg};
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_frame_reg <= current_frame;
            s1_prod_reg  <= fca_pkg::PROD_W'(elapsed_time) * fca_pkg::PROD_W'(time_scale);
        end
    end

endmodule

`default_nettype wire

// ===== design/fca_back.sv =====
`default_nettype none

module fca_back #(
    parameter int FRAME_WIDTH = 24,
    parameter int MAX_EVENTS  = 3
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   q_empty,
    output logic                                        q_pop,
    input  wire logic [1+fca_pkg::REM_W+FRAME_WIDTH-1:0] q_rdata,
    input  wire logic signed [FRAME_WIDTH-1:0]          start_frame,
    input  wire logic signed [FRAME_WIDTH-1:0]          end_frame,
    input  wire logic                                   loop_enable,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [FRAME_WIDTH-1:0]               new_frame,
    output logic        [1:0]                           loop_count,
    output logic                                        done_res
);

    localparam int WIDE = (FRAME_WIDTH > fca_pkg::REM_W) ? FRAME_WIDTH : fca_pkg::REM_W;
    localparam int RW   = WIDE + 3;
    localparam int EV_W = $clog2(MAX_EVENTS + 1);
    localparam int HI_W = RW - FRAME_WIDTH + 1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                     state_reg;
    logic signed [RW-1:0]       frame_reg;
    logic signed [RW-1:0]       remain_reg;
    logic        [EV_W-1:0]     events_reg;
    logic        [1:0]          loops_reg;
    logic                       done_reg;
    logic                       out_valid_reg;
    logic signed [FRAME_WIDTH-1:0] new_frame_reg;
    logic        [1:0]          loop_count_reg;
    logic                       done_res_reg;

    logic signed [FRAME_WIDTH-1:0] q_frame;
    logic        [fca_pkg::REM_W-1:0] q_remain;
    logic                       q_single;
    logic signed [RW-1:0]       lo;
    logic signed [RW-1:0]       till;
    logic                       busy;
    logic                       out_free;
    logic                       emit;
    logic        [HI_W-1:0]     hi_bits;
    logic signed [FRAME_WIDTH-1:0] sat_frame;

    assign {q_single, q_remain, q_frame} = q_rdata;
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign out_free   = !out_valid_reg || !out_stall;
    assign emit       = (state_reg == ST_RUN) && !busy && out_free;
    assign out_valid  = out_valid_reg;
    assign new_frame  = new_frame_reg;
    assign loop_count = loop_count_reg;
    assign done_res   = done_res_reg;

    always_comb
    begin
        lo   = (start_frame < end_frame) ? RW'(start_frame) : RW'(end_frame);
        till = RW'(end_frame) - frame_reg
             + (loop_enable ? RW'(fca_pkg::ONE_FRAME) : RW'(0));
        busy = !remain_reg[RW-1] && (|remain_reg)
             && (events_reg < EV_W'(MAX_EVENTS));
        // clamp to the signed frame range
        hi_bits = frame_reg[RW-1:FRAME_WIDTH-1];
        if ((&hi_bits) || !(|hi_bits))
        begin
            sat_frame = frame_reg[FRAME_WIDTH-1:0];
        end
        else if (frame_reg[RW-1])
        begin
            sat_frame = {1'b1, {(FRAME_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat_frame = {1'b0, {(FRAME_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            frame_reg      <= '0;
            remain_reg     <= '0;
            events_reg     <= '0;
            loops_reg      <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            new_frame_reg  <= '0;
            loop_count_reg <= '0;
            done_res_reg   <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        events_reg <= '0;
                        loops_reg  <= '0;
                        done_reg   <= 1'b0;
                        if (q_single)
                        begin
                            frame_reg  <= RW'(end_frame);
                            remain_reg <= '0;
                        end
                        else
                        begin
                            frame_reg  <= RW'(q_frame);
                            remain_reg <= RW'(q_remain);
                        end
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (busy)
                    begin
                        if (remain_reg >= till)
                        begin
                            events_reg <= events_reg + EV_W'(1);
                            if (loop_enable)
                            begin
                                // wrap to the clip start with one extra frame
                                remain_reg <= remain_reg - till;
                                frame_reg  <= lo;
                                if (loops_reg != 2'd3)
                                begin
                                    loops_reg <= loops_reg + 2'd1;
                                end
                            end
                            else
                            begin
                                frame_reg  <= RW'(end_frame);
                                remain_reg <= '0;
                                done_reg   <= 1'b1;
                            end
                        end
                        else
                        begin
                            frame_reg  <= frame_reg + remain_reg;
                            remain_reg <= '0;
                        end
                    end
                    else if (out_free)
                    begin
                        new_frame_reg  <= sat_frame;
                        loop_count_reg <= loops_reg;
                        done_res_reg   <= done_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/frame_clock_accumulator_top.sv =====
// Frame clock accumulator: advances an animation frame position by one time step.
// Input channel (in_valid / in_stall) carries current_frame (signed Q.8),
// elapsed_time (Q0.16 s) and time_scale (Q8.8); each word yields exactly one
// output word (new_frame, loop_count, done_res) on out_valid / out_stall.
// Clip bounds and the loop mode come from the write port (cfg_we, cfg_index,
// cfg_data): 0 start_frame, 1 end_frame, 2 loop_enable; other indexes are ignored.
// Write them only while the block is empty.
// The front stage registers the time product and pushes the step length into a
// two-entry queue; the back unit runs one wrap event per cycle.
// An input word passes the front stage register and a queue entry; the back unit
// pops it in ST_IDLE, runs its advance, wrap or end events in ST_RUN (wraps and
// ends at most MAX_EVENTS), then registers the output word. The back unit holds
// one word at a time; the front keeps accepting until the queue fills.
// Reset clears the registers to zero (single-frame clip, no looping) and empties
// the pipeline. A stalled output word holds; the back unit then waits and the
// queue and front stage fill before in_stall rises.
`default_nettype none

module frame_clock_accumulator_top #(
    parameter int FRAME_WIDTH = 24,
    parameter int MAX_EVENTS  = 3
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [fca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [FRAME_WIDTH-1:0]             cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [FRAME_WIDTH-1:0]      current_frame,
    input  wire logic        [fca_pkg::ET_W-1:0]    elapsed_time,
    input  wire logic        [fca_pkg::TS_W-1:0]    time_scale,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [FRAME_WIDTH-1:0]           new_frame,
    output logic        [1:0]                       loop_count,
    output logic                                    done_res
);

    localparam int QW = 1 + fca_pkg::REM_W + FRAME_WIDTH;

    logic signed [FRAME_WIDTH-1:0] start_frame_reg;
    logic signed [FRAME_WIDTH-1:0] end_frame_reg;
    logic                          loop_enable_reg;
    logic                          q_push;
    logic                          q_pop;
    logic                          q_full;
    logic                          q_empty;
    logic [QW-1:0]                 q_wdata;
    logic [QW-1:0]                 q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_frame_reg <= '0;
            end_frame_reg   <= '0;
            loop_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fca_pkg::REG_START_FRAME: start_frame_reg <= cfg_data;
                fca_pkg::REG_END_FRAME:   end_frame_reg   <= cfg_data;
                fca_pkg::REG_LOOP_ENABLE: loop_enable_reg <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    fca_front #(
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .current_frame (current_frame),
        .elapsed_time  (elapsed_time),
        .time_scale    (time_scale),
        .start_frame   (start_frame_reg),
        .end_frame     (end_frame_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    fca_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    fca_back #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .MAX_EVENTS  (MAX_EVENTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_rdata     (q_rdata),
        .start_frame (start_frame_reg),
        .end_frame   (end_frame_reg),
        .loop_enable (loop_enable_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .new_frame   (new_frame),
        .loop_count  (loop_count),
        .done_res    (done_res)
    );

endmodule

`default_nettype wire
